@@ rtl/core/ptm_pkg.sv @@
package ptm_pkg;

    // Address split: directory index, table index, page offset
    localparam int VA_W     = 32;
    localparam int IDX_W    = 10;
    localparam int OFF_W    = 12;
    localparam int FRAME_W  = VA_W - OFF_W;
    localparam int FLAGS_W  = 12;
    localparam int PTE_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int POOL_TABLES_DEF   = 8;

    localparam logic [FUNC_W-1:0] F_MAP    = 2'd0;
    localparam logic [FUNC_W-1:0] F_UNMAP  = 2'd1;
    localparam logic [FUNC_W-1:0] F_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_OUT = 2'd2;

endpackage

@@ rtl/core/two_level_page_table_map.sv @@
// Two-level page table engine. A request is taken when start is high and busy
// is low; its result appears for exactly one cycle with o_valid and cannot be
// held off. After reset the block sweeps the directory memory, one slot per
// cycle, and stays busy until every slot is cleared. Map, unmap, a miss and an
// unknown code pass through index reduction with directory read (S_DIR), then
// table read/write (S_PTE). A lookup of a present table adds the state S_RD,
// since the entry read on the pool memory needs the table number that the
// directory read returns. A map that allocates a new table adds a sweep (S_CLR):
// the new table is cleared one entry per cycle and the mapped entry is written in
// that sweep. The result strobe comes in the first cycle with busy low, so the
// next request can be taken in that same cycle.
module two_level_page_table_map #(
    parameter int DIR_ENTRIES   = ptm_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = ptm_pkg::TABLE_ENTRIES_DEF,
    parameter int POOL_TABLES   = ptm_pkg::POOL_TABLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ptm_pkg::FUNC_W-1:0]      i_func,
    input  logic [ptm_pkg::VA_W-1:0]        i_virt_addr,
    input  logic [ptm_pkg::VA_W-1:0]        i_phys_addr,
    input  logic [ptm_pkg::FLAGS_W-1:0]     i_flags,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [ptm_pkg::VA_W-1:0]        o_phys_frame,
    output logic [ptm_pkg::STATUS_W-1:0]    o_status
);
    import ptm_pkg::*;

    localparam int DAW   = $clog2(DIR_ENTRIES);
    localparam int TAW   = $clog2(TABLE_ENTRIES);
    localparam int TBL_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_W = $clog2(POOL_TABLES + 1);
    localparam int PAW   = TBL_W + TAW;
    localparam int SW    = (DAW > TAW) ? DAW : TAW;
    localparam int DIR_W = TBL_W + 1;

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_DIR  = 6'b000100,
        S_PTE  = 6'b001000,
        S_CLR  = 6'b010000,
        S_RD   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_next, n_next;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [FRAME_W-1:0]   r_pa, n_pa;
    logic [FLAGS_W-1:0]   r_flags, n_flags;
    logic [DAW-1:0]       r_di, n_di;
    logic [TAW-1:0]       r_ti, n_ti;
    logic [TBL_W-1:0]     r_tbl, n_tbl;
    logic                 r_valid, n_valid;
    logic                 r_hit, n_hit;
    logic [VA_W-1:0]      r_frame, n_frame;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic [DAW-1:0]       w_di;
    logic [TAW-1:0]       w_ti;
    logic                 dir_we;
    logic [DAW-1:0]       dir_addr;
    logic [DIR_W-1:0]     dir_wdata;
    logic [DIR_W-1:0]     dir_rdata;
    logic                 pool_we;
    logic [PAW-1:0]       pool_addr;
    logic [PTE_W-1:0]     pool_wdata;
    logic [PTE_W-1:0]     pool_rdata;
    logic                 w_dvalid;
    logic [TBL_W-1:0]     w_dtbl;
    logic [PTE_W-1:0]     w_entry;
    logic                 w_accept;

    assign w_accept = start & ~busy;

    ptm_mod #(.DIVISOR(DIR_ENTRIES)) u_dir_idx (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_x    (i_virt_addr[VA_W-1 -: IDX_W]),
        .o_rem  (w_di)
    );

    ptm_mod #(.DIVISOR(TABLE_ENTRIES)) u_tbl_idx (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_x    (i_virt_addr[OFF_W +: IDX_W]),
        .o_rem  (w_ti)
    );

    ptm_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_addr  (dir_addr),
        .i_wdata (dir_wdata),
        .o_rdata (dir_rdata)
    );

    ptm_ram #(.WIDTH(PTE_W), .DEPTH(1 << PAW)) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_addr  (pool_addr),
        .i_wdata (pool_wdata),
        .o_rdata (pool_rdata)
    );

    assign w_dvalid = dir_rdata[TBL_W];
    assign w_dtbl   = dir_rdata[TBL_W-1:0];
    assign w_entry  = {r_pa, r_flags};

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_next     = r_next;
        n_func     = r_func;
        n_pa       = r_pa;
        n_flags    = r_flags;
        n_di       = r_di;
        n_ti       = r_ti;
        n_tbl      = r_tbl;
        n_valid    = 1'b0;
        n_hit      = 1'b0;
        n_frame    = '0;
        n_status   = ST_DONE;
        dir_we     = 1'b0;
        dir_addr   = r_di;
        dir_wdata  = {1'b1, r_next[TBL_W-1:0]};
        pool_we    = 1'b0;
        pool_addr  = {w_dtbl, r_ti};
        pool_wdata = w_entry;

        unique case (r_state)
            S_INIT: begin
                dir_we    = 1'b1;
                dir_addr  = r_cnt[DAW-1:0];
                dir_wdata = '0;
                n_cnt     = r_cnt + SW'(1);
                if (r_cnt == SW'(DIR_ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_pa    = i_phys_addr[VA_W-1:OFF_W];
                    n_flags = i_flags;
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                dir_addr = w_di;
                n_di     = w_di;
                n_ti     = w_ti;
                n_state  = S_PTE;
            end
            S_PTE: begin
                unique case (r_func) inside
                    F_MAP: begin
                        if (w_dvalid) begin
                            pool_we = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_next >= CNT_W'(POOL_TABLES)) begin
                            n_status = ST_POOL_OUT;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            dir_we  = 1'b1;
                            n_tbl   = r_next[TBL_W-1:0];
                            n_next  = r_next + CNT_W'(1);
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                    end
                    F_UNMAP, F_LOOKUP: begin
                        if (!w_dvalid) begin
                            n_status = ST_NO_TABLE;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else if (r_func == F_UNMAP) begin
                            pool_we    = 1'b1;
                            pool_wdata = '0;
                            n_valid    = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            // entry read issued at {table, index} this cycle
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CLR: begin
                // clear the new table; the mapped entry gets its value in the same sweep
                pool_we    = 1'b1;
                pool_addr  = {r_tbl, r_cnt[TAW-1:0]};
                pool_wdata = (r_cnt[TAW-1:0] == r_ti) ? w_entry : '0;
                n_cnt      = r_cnt + SW'(1);
                if (r_cnt == SW'(TABLE_ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                if (pool_rdata != '0) begin
                    n_hit   = 1'b1;
                    n_frame = {pool_rdata[PTE_W-1:OFF_W], OFF_W'(0)};
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_next  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_next  <= n_next;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_pa     <= n_pa;
        r_flags  <= n_flags;
        r_di     <= n_di;
        r_ti     <= n_ti;
        r_tbl    <= n_tbl;
        r_hit    <= n_hit;
        r_frame  <= n_frame;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_phys_frame = r_frame;
    assign o_status     = r_status;

    a_valid_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    a_pool_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= CNT_W'(POOL_TABLES))
        else $error("table allocation count past pool size");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_hit) |-> (r_status == ST_DONE && r_func == F_LOOKUP))
        else $error("hit on a non-lookup or failed transfer");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PTE && n_state == S_CLR) |=> (r_next == $past(r_next) + CNT_W'(1)))
        else $error("table allocation did not advance the pool count");
endmodule

@@ rtl/core/ptm_ram.sv @@
module ptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/ptm_mod.sv @@
// Index reduction modulo a constant: quotient estimate by reciprocal multiply
// (registered), remainder and one correction step in the following cycle.
module ptm_mod #(
    parameter int DIVISOR = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [ptm_pkg::IDX_W-1:0]     i_x,
    output logic [$clog2(DIVISOR)-1:0]    o_rem
);
    import ptm_pkg::*;

    localparam int SH     = 2 * IDX_W;
    localparam int PROD_W = 3 * IDX_W;
    localparam int OUT_W  = $clog2(DIVISOR);
    localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / DIVISOR);

    logic [IDX_W-1:0]  r_x;
    logic [IDX_W-1:0]  r_q;
    logic [PROD_W-1:0] w_prod;
    logic [SH:0]       w_qc;
    logic [IDX_W:0]    w_r;
    logic [IDX_W:0]    w_rem;

    assign w_prod = PROD_W'(i_x) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_x;
            r_q <= w_prod[PROD_W-1:SH];
        end
    end

    // estimate is exact or one low, so the remainder is below twice the divisor
    assign w_qc  = (SH+1)'(r_q) * (SH+1)'(DIVISOR);
    assign w_r   = (IDX_W+1)'(r_x) - (IDX_W+1)'(w_qc[IDX_W-1:0]);
    assign w_rem = (w_r >= (IDX_W+1)'(DIVISOR)) ? w_r - (IDX_W+1)'(DIVISOR) : w_r;
    assign o_rem = w_rem[OUT_W-1:0];
endmodule
